// File: rtl/core/vsp_pkg.sv
// ----------------------------------------------------------------------------
// vsp_pkg
// Shared widths, pipeline depths and the root step function for the sphere projection.
// ----------------------------------------------------------------------------
package vsp_pkg;

  localparam int COORD_W = 24;
  localparam int RAD_W   = 23;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int LEN_W   = SQ_W / 2;
  localparam int RREM_W  = LEN_W + 2;
  localparam int PROD_W  = COORD_W + RAD_W;
  localparam int Q_W     = RAD_W;

  localparam int SQ_LAT   = 2;
  localparam int SUM_LAT  = 1;
  localparam int ROOT_LAT = LEN_W;
  localparam int DIV_LAT  = Q_W + 2;
  localparam int TOT_LAT  = SQ_LAT + SUM_LAT + ROOT_LAT + DIV_LAT;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(65536);

  typedef struct packed {
    logic [RREM_W-1:0] rem;
    logic [LEN_W-1:0]  root;
  } root_st_t;

  // one root digit: bring in two bits of the radicand
  function automatic root_st_t root_step(root_st_t s, logic [1:0] pair);
    logic [RREM_W+1:0] cur;
    logic [RREM_W+1:0] trial;
    root_st_t          o;
    cur   = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (cur >= trial) begin
      o.rem  = RREM_W'(cur - trial);
      o.root = {s.root[LEN_W-2:0], 1'b1};
    end else begin
      o.rem  = RREM_W'(cur);
      o.root = {s.root[LEN_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// File: rtl/core/vsp_sq.sv
// ----------------------------------------------------------------------------
// vsp_sq
// Per-lane magnitude and square of one coordinate, two stages.
// ----------------------------------------------------------------------------
module vsp_sq import vsp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [COORD_W-1:0] coord,
  output logic [COORD_W-1:0] mag_o,
  output logic               neg_o,
  output logic [SQ_W-1:0]    sq_o
);

  logic [COORD_W-1:0] mag_r;
  logic               neg_r;
  logic [COORD_W-1:0] mag2_r;
  logic               neg2_r;
  logic [SQ_W-1:0]    sq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= coord[COORD_W-1];
      // most negative value maps to 2^(w-1) unsigned
      mag_r  <= coord[COORD_W-1] ? COORD_W'(~coord + 1'b1) : coord;
      neg2_r <= neg_r;
      mag2_r <= mag_r;
      sq_r   <= {{COORD_W{1'b0}}, mag_r} * {{COORD_W{1'b0}}, mag_r};
    end
  end

  assign mag_o = mag2_r;
  assign neg_o = neg2_r;
  assign sq_o  = sq_r;

endmodule

// File: rtl/core/vsp_root.sv
// ----------------------------------------------------------------------------
// vsp_root
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vsp_root import vsp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_W-1:0]  rad,
  output logic [LEN_W-1:0] len_o
);

  root_st_t        st_r  [LEN_W];
  logic [SQ_W-1:0] rad_r [LEN_W];

  genvar g;
  generate
    for (g = 0; g < LEN_W; g++) begin : g_stage
      localparam int B = LEN_W - 1 - g;
      if (g == 0) begin : g_first
        root_st_t zero_st;
        assign zero_st = '0;
        always_ff @(posedge clk) begin
          if (en) begin
            st_r[g]  <= root_step(zero_st, rad[2*B+1 -: 2]);
            rad_r[g] <= rad;
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en) begin
            st_r[g]  <= root_step(st_r[g-1], rad_r[g-1][2*B+1 -: 2]);
            rad_r[g] <= rad_r[g-1];
          end
        end
      end
    end
  endgenerate

  assign len_o = st_r[LEN_W-1].root;

endmodule

// File: rtl/core/vsp_div.sv
// ----------------------------------------------------------------------------
// vsp_div
// Per-lane scale: magnitude times radius, pipelined divide by length, sign.
// ----------------------------------------------------------------------------
module vsp_div import vsp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [COORD_W-1:0] mag,
  input  logic               neg,
  input  logic               zero,
  input  logic [LEN_W-1:0]   len,
  input  logic [RAD_W-1:0]   radius,
  output logic [COORD_W-1:0] proj_o,
  output logic               zero_o
);

  logic [PROD_W-1:0]  rem_r  [Q_W+1];
  logic [Q_W-1:0]     q_r    [Q_W+1];
  logic [LEN_W-1:0]   len_r  [Q_W+1];
  logic               neg_r  [Q_W+1];
  logic               zero_r [Q_W+1];
  logic [COORD_W-1:0] proj_r;
  logic               zf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= PROD_W'({{RAD_W{1'b0}}, mag} * {{COORD_W{1'b0}}, radius});
      q_r[0]    <= '0;
      len_r[0]  <= len;
      neg_r[0]  <= neg;
      zero_r[0] <= zero;
    end
  end

  // quotient never exceeds the radius since magnitude <= length
  genvar g;
  generate
    for (g = 1; g <= Q_W; g++) begin : g_stage
      localparam int B = Q_W - g;
      logic [PROD_W-1:0] dsh;
      assign dsh = {{(PROD_W-LEN_W){1'b0}}, len_r[g-1]} << B;
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_r[g-1] >= dsh) begin
            rem_r[g] <= rem_r[g-1] - dsh;
            q_r[g]   <= q_r[g-1] | (Q_W'(1) << B);
          end else begin
            rem_r[g] <= rem_r[g-1];
            q_r[g]   <= q_r[g-1];
          end
          len_r[g]  <= len_r[g-1];
          neg_r[g]  <= neg_r[g-1];
          zero_r[g] <= zero_r[g-1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r <= zero_r[Q_W];
      if (zero_r[Q_W]) begin
        proj_r <= '0;
      end else if (neg_r[Q_W]) begin
        proj_r <= COORD_W'(~{1'b0, q_r[Q_W]} + 1'b1);
      end else begin
        proj_r <= {1'b0, q_r[Q_W]};
      end
    end
  end

  assign proj_o = proj_r;
  assign zero_o = zf_r;

endmodule

// File: rtl/core/vertex_sphere_projection_unit.sv
// ----------------------------------------------------------------------------
// vertex_sphere_projection_unit
// Scales each 3D vertex so its length equals the configured sphere radius.
// ----------------------------------------------------------------------------
// One vertex is taken every clock unless the output stalls. Three
// coordinate lanes form magnitudes and squares, a 24-stage root pipeline gives
// the floor length, and each lane runs a 23-stage restoring divider. The whole
// pipeline advances whenever the output register is empty or being drained, so
// a stalled output holds every stage. A zero vertex gives zero coordinates and
// sets zero_length. Write the radius only while no vertex is in flight.
module vertex_sphere_projection_unit import vsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3*COORD_W-1:0] in_tdata,   // coord_x, coord_y, coord_z
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3*COORD_W-1:0] out_tdata,  // proj_x, proj_y, proj_z
  output logic [0:0]           out_tuser,  // zero_length
  input  logic                 cfg_wr_en,
  input  logic [RAD_W-1:0]     cfg_wr_data
);

  logic               en;
  logic [TOT_LAT-1:0] vld_r;
  logic [RAD_W-1:0]   radius_r;

  logic [COORD_W-1:0] mag   [3];
  logic               neg   [3];
  logic [SQ_W-1:0]    sq    [3];
  logic [COORD_W-1:0] proj  [3];
  logic               zf    [3];

  logic [SQ_W-1:0]    sum_r;
  logic [COORD_W-1:0] smag_r [3];
  logic               sneg_r [3];
  logic [LEN_W-1:0]   len;

  logic [COORD_W-1:0] dmag_r  [ROOT_LAT][3];
  logic               dneg_r  [ROOT_LAT][3];
  logic               dzero_r [ROOT_LAT];

  assign en        = ~vld_r[TOT_LAT-1] | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      radius_r <= RADIUS_RST;
    end else begin
      if (en) begin
        vld_r <= {vld_r[TOT_LAT-2:0], in_tvalid};
      end
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
    end
  end

  genvar l, d;
  generate
    for (l = 0; l < 3; l++) begin : g_lane
      vsp_sq u_sq (
        .clk   (clk),
        .en    (en),
        .coord (in_tdata[l*COORD_W +: COORD_W]),
        .mag_o (mag[l]),
        .neg_o (neg[l]),
        .sq_o  (sq[l])
      );

      always_ff @(posedge clk) begin
        if (en) begin
          smag_r[l] <= mag[l];
          sneg_r[l] <= neg[l];
        end
      end

      // hold magnitudes while the root is worked out
      for (d = 0; d < ROOT_LAT; d++) begin : g_dly
        always_ff @(posedge clk) begin
          if (en) begin
            dmag_r[d][l] <= (d == 0) ? smag_r[l] : dmag_r[(d == 0) ? 0 : d-1][l];
            dneg_r[d][l] <= (d == 0) ? sneg_r[l] : dneg_r[(d == 0) ? 0 : d-1][l];
          end
        end
      end

      vsp_div u_div (
        .clk    (clk),
        .en     (en),
        .mag    (dmag_r[ROOT_LAT-1][l]),
        .neg    (dneg_r[ROOT_LAT-1][l]),
        .zero   (dzero_r[ROOT_LAT-1]),
        .len    (len),
        .radius (radius_r),
        .proj_o (proj[l]),
        .zero_o (zf[l])
      );

      assign out_tdata[l*COORD_W +: COORD_W] = proj[l];
    end

    for (d = 0; d < ROOT_LAT; d++) begin : g_zdly
      always_ff @(posedge clk) begin
        if (en) begin
          dzero_r[d] <= (d == 0) ? (sum_r == '0) : dzero_r[(d == 0) ? 0 : d-1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sq[0] + sq[1] + sq[2];
    end
  end

  vsp_root u_root (
    .clk   (clk),
    .en    (en),
    .rad   (sum_r),
    .len_o (len)
  );

  assign out_tvalid   = vld_r[TOT_LAT-1];
  assign out_tuser[0] = zf[0] & zf[1] & zf[2];

endmodule

// File: rtl/core/vsp_checker.sv
// ----------------------------------------------------------------------------
// vsp_checker
// Port-level checks for the sphere projection unit.
// ----------------------------------------------------------------------------
module vsp_checker import vsp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [3*COORD_W-1:0] out_tdata,
  input logic [0:0]           out_tuser
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero vertex with nonzero result");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free output");

endmodule

bind vertex_sphere_projection_unit vsp_checker u_vsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
